FILE: rtl/lidar_follow_gap_heading_defines.svh
// ----------------------------------------------------------------------------
// lidar_follow_gap_heading_defines.svh
// Assertion macros for the follow-the-gap heading block.
// ----------------------------------------------------------------------------
`ifndef LIDAR_FOLLOW_GAP_HEADING_DEFINES_SVH
`define LIDAR_FOLLOW_GAP_HEADING_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every clock edge out of reset.
`define LFGH_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfgh assertion failed");

// Next-cycle implication, checked on every clock edge out of reset.
`define LFGH_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfgh assertion failed");

`else

`define LFGH_ASSERT_NOW(name, ante, cons)
`define LFGH_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: rtl/lfgh_pkg.sv
// ----------------------------------------------------------------------------
// lfgh_pkg
// Widths, constants and register codes of the follow-the-gap heading block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfgh_pkg;

    // Largest scan supported by the beam index fields
    localparam int unsigned MAX_BEAMS = 2048;
    localparam int unsigned FIELD_CAP = 2048;
    localparam int unsigned SCAN_CAP  = (MAX_BEAMS < FIELD_CAP) ? MAX_BEAMS : FIELD_CAP;

    // Field widths
    localparam int unsigned IDX_W    = 11;   // beam index
    localparam int unsigned POS_W    = 12;   // beam index or one past it
    localparam int unsigned RANGE_W  = 16;
    localparam int unsigned WHALF_W  = 8;
    localparam int unsigned WCNT_W   = 9;    // up to 2 * 255 + 1 beams
    localparam int unsigned TOTAL_W  = 25;
    localparam int unsigned ANGLE_W  = 23;
    localparam int unsigned STEP_W   = 17;
    localparam int unsigned PROD_W   = POS_W + STEP_W;
    localparam int unsigned SUM_W    = PROD_W + 2;
    localparam int unsigned CFG_W    = 23;
    localparam int unsigned CFG_IDX_W = 3;

    // Heading saturation, microradians
    localparam int signed PI_URAD = 3141593;

    // Register reset values
    localparam logic [POS_W-1:0]          RST_SCAN_LENGTH = 12'd1080;
    localparam logic [RANGE_W-1:0]        RST_CLIP_LIMIT  = 16'd3000;
    localparam logic [RANGE_W-1:0]        RST_GAP_THR     = 16'd1500;
    localparam logic [RANGE_W-1:0]        RST_DETECT_THR  = 16'd1500;
    localparam logic [WHALF_W-1:0]        RST_WIN_HALF    = 8'd35;
    localparam logic signed [ANGLE_W-1:0] RST_ANGLE_MIN   = -23'sd2356194;
    localparam logic [STEP_W-1:0]         RST_ANGLE_STEP  = 17'd4363;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCAN_LENGTH = 3'd0,
        CFG_CLIP_LIMIT  = 3'd1,
        CFG_GAP_THR     = 3'd2,
        CFG_DETECT_THR  = 3'd3,
        CFG_WIN_HALF    = 3'd4,
        CFG_ANGLE_MIN   = 3'd5,
        CFG_ANGLE_STEP  = 3'd6
    } cfg_index_t;

endpackage

FILE: rtl/lidar_follow_gap_heading.sv
// ----------------------------------------------------------------------------
// lidar_follow_gap_heading
// Follow-the-gap steering from a stream of lidar ranges.
//
// Input channel: one beam range per beat (in_valid / in_stall), beams of a
// scan in order. Output channel: one result beat per scan (out_valid /
// out_stall), carrying gap bounds, midpoint index, heading and obstacle flag.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index; write
// only while the block is idle.
// Throughput: one beam per cycle while in_stall is low; the per-beam run and
// window update closes combinationally off the input register.
// The result of a scan passes the input register, gap close, midpoint,
// multiply and saturate stages after its last beam is taken.
// Reset: all scan state and the obstacle flag clear; registers take their
// defaults. A stalled result holds on the ports; beams keep flowing until the
// last beam of a scan finds the internal result stages full, then in_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "lidar_follow_gap_heading_defines.svh"

module lidar_follow_gap_heading
    import lfgh_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [RANGE_W-1:0]        beam_range_mm,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [ANGLE_W-1:0] heading_urad,
    output logic [POS_W-1:0]          target_index,
    output logic [IDX_W-1:0]          largest_gap_start,
    output logic [POS_W-1:0]          largest_gap_end,
    output logic                      obstacle_seen
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [POS_W-1:0]          scan_length_reg;
    logic [RANGE_W-1:0]        clip_limit_reg;
    logic [RANGE_W-1:0]        gap_thr_reg;
    logic [RANGE_W-1:0]        detect_thr_reg;
    logic [WHALF_W-1:0]        win_half_reg;
    logic signed [ANGLE_W-1:0] angle_min_reg;
    logic [STEP_W-1:0]         angle_step_reg;

    // Decode register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_length_reg <= RST_SCAN_LENGTH;
            clip_limit_reg  <= RST_CLIP_LIMIT;
            gap_thr_reg     <= RST_GAP_THR;
            detect_thr_reg  <= RST_DETECT_THR;
            win_half_reg    <= RST_WIN_HALF;
            angle_min_reg   <= RST_ANGLE_MIN;
            angle_step_reg  <= RST_ANGLE_STEP;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SCAN_LENGTH: scan_length_reg <= cfg_data[POS_W-1:0];
                CFG_CLIP_LIMIT:  clip_limit_reg  <= cfg_data[RANGE_W-1:0];
                CFG_GAP_THR:     gap_thr_reg     <= cfg_data[RANGE_W-1:0];
                CFG_DETECT_THR:  detect_thr_reg  <= cfg_data[RANGE_W-1:0];
                CFG_WIN_HALF:    win_half_reg    <= cfg_data[WHALF_W-1:0];
                CFG_ANGLE_MIN:   angle_min_reg   <= signed'(cfg_data[ANGLE_W-1:0]);
                CFG_ANGLE_STEP:  angle_step_reg  <= cfg_data[STEP_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Scan geometry from the registers
    // ------------------------------------------------------------------
    localparam logic [POS_W-1:0] SCAN_CAP_V = POS_W'(SCAN_CAP);

    logic [POS_W-1:0]   len_eff;
    logic [IDX_W-1:0]   mid;
    logic [IDX_W-1:0]   win_lo;
    logic [POS_W:0]     win_hi_raw;
    logic [POS_W-1:0]   win_hi;
    logic [POS_W-1:0]   win_span;
    logic [TOTAL_W-1:0] detect_prod_reg;

    // Clamp the scan length and place the window around the middle beam
    always_comb
    begin
        if (scan_length_reg == '0)
            len_eff = POS_W'(1);
        else if (scan_length_reg > SCAN_CAP_V)
            len_eff = SCAN_CAP_V;
        else
            len_eff = scan_length_reg;

        mid = len_eff[POS_W-1:1];

        if (mid >= IDX_W'(win_half_reg))
            win_lo = mid - IDX_W'(win_half_reg);
        else
            win_lo = '0;

        win_hi_raw = (POS_W+1)'(mid) + (POS_W+1)'(win_half_reg) + (POS_W+1)'(1);
        if (win_hi_raw > (POS_W+1)'(len_eff))
            win_hi = len_eff;
        else
            win_hi = win_hi_raw[POS_W-1:0];

        win_span = win_hi - POS_W'(win_lo);
    end

    // Hold the detection limit: threshold times beams in the window
    always_ff @(posedge clk)
    begin
        detect_prod_reg <= TOTAL_W'(detect_thr_reg * win_span[WCNT_W-1:0]);
    end

    // ------------------------------------------------------------------
    // Pipeline valid bits and flow control
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic a_valid_reg;
    logic b_valid_reg;
    logic c_valid_reg;
    logic out_valid_reg;

    logic out_ready;
    logic c_ready;
    logic b_ready;
    logic a_ready;
    logic in_ready;
    logic proc;

    assign out_ready = !out_valid_reg || !out_stall;
    assign c_ready   = !c_valid_reg || out_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_ready  = !in_valid_reg || proc;
    assign in_stall  = !in_ready;

    // ------------------------------------------------------------------
    // Per-beam scan state
    // ------------------------------------------------------------------
    logic [RANGE_W-1:0] in_range_reg;
    logic [IDX_W-1:0]   beam_counter_reg, beam_counter_next;
    logic               run_open_reg, run_open_next;
    logic [IDX_W-1:0]   run_begin_reg, run_begin_next;
    logic [IDX_W-1:0]   best_begin_reg, best_begin_next;
    logic [POS_W-1:0]   best_finish_reg, best_finish_next;
    logic [POS_W-1:0]   best_length_reg, best_length_next;
    logic [TOTAL_W-1:0] window_total_reg, window_total_next;
    logic               obstacle_latch_reg, obstacle_latch_next;

    logic [RANGE_W-1:0] clipped;
    logic               above;
    logic [POS_W-1:0]   beam_pos;
    logic               last_beam;
    logic               close_en;
    logic [IDX_W-1:0]   close_begin;
    logic [POS_W-1:0]   close_finish;
    logic [POS_W-1:0]   close_len;
    logic               better;
    logic [IDX_W-1:0]   cand_begin;
    logic [POS_W-1:0]   cand_finish;
    logic [POS_W-1:0]   cand_length;
    logic               in_window;
    logic [TOTAL_W-1:0] total_new;

    // Clip, track the run and accumulate the window
    always_comb
    begin
        clipped   = (in_range_reg > clip_limit_reg) ? clip_limit_reg : in_range_reg;
        above     = clipped > gap_thr_reg;
        beam_pos  = POS_W'(beam_counter_reg);
        last_beam = (beam_pos + POS_W'(1)) >= len_eff;

        // A run closes on a low beam, or at the scan end if still high
        close_en     = (run_open_reg && !above) || (last_beam && above);
        close_begin  = run_open_reg ? run_begin_reg : beam_counter_reg;
        close_finish = above ? beam_pos + POS_W'(1) : beam_pos;
        close_len    = close_finish - POS_W'(close_begin);
        better       = close_en && (close_len > best_length_reg);

        cand_begin  = better ? close_begin  : best_begin_reg;
        cand_finish = better ? close_finish : best_finish_reg;
        cand_length = better ? close_len    : best_length_reg;

        in_window = (beam_pos >= POS_W'(win_lo)) && (beam_pos < win_hi);
        total_new = window_total_reg + (in_window ? TOTAL_W'(in_range_reg) : '0);

        proc = in_valid_reg && (!last_beam || a_ready);
    end

    // Advance the scan state or clear it after the last beam
    always_comb
    begin
        beam_counter_next = beam_counter_reg;
        run_open_next     = run_open_reg;
        run_begin_next    = run_begin_reg;
        best_begin_next   = best_begin_reg;
        best_finish_next  = best_finish_reg;
        best_length_next  = best_length_reg;
        window_total_next = window_total_reg;

        if (proc)
        begin
            if (last_beam)
            begin
                beam_counter_next = '0;
                run_open_next     = 1'b0;
                run_begin_next    = '0;
                best_begin_next   = '0;
                best_finish_next  = '0;
                best_length_next  = '0;
                window_total_next = '0;
            end
            else
            begin
                beam_counter_next = beam_counter_reg + IDX_W'(1);
                run_open_next     = above;
                run_begin_next    = (above && !run_open_reg) ? beam_counter_reg
                                                             : run_begin_reg;
                best_begin_next   = cand_begin;
                best_finish_next  = cand_finish;
                best_length_next  = cand_length;
                window_total_next = total_new;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result stages
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]   a_begin_reg;
    logic [POS_W-1:0]   a_finish_reg;
    logic [TOTAL_W-1:0] a_total_reg;

    logic [IDX_W-1:0]   b_begin_reg;
    logic [POS_W-1:0]   b_finish_reg;
    logic [POS_W-1:0]   b_target_reg;
    logic               b_obstacle_reg;

    logic [IDX_W-1:0]   c_begin_reg;
    logic [POS_W-1:0]   c_finish_reg;
    logic [POS_W-1:0]   c_target_reg;
    logic               c_obstacle_reg;
    logic [PROD_W-1:0]  c_prod_reg;

    logic signed [ANGLE_W-1:0] out_heading_reg;
    logic [POS_W-1:0]          out_target_reg;
    logic [IDX_W-1:0]          out_begin_reg;
    logic [POS_W-1:0]          out_finish_reg;
    logic                      out_obstacle_reg;

    logic                      a_move;
    logic                      b_move;
    logic                      c_move;
    logic [POS_W-1:0]          target;
    logic                      below;
    logic signed [SUM_W-1:0]   heading_sum;
    logic signed [ANGLE_W-1:0] heading_sat;

    assign a_move = a_valid_reg && b_ready;
    assign b_move = b_valid_reg && c_ready;
    assign c_move = c_valid_reg && out_ready;

    // Midpoint, window compare and heading saturation
    always_comb
    begin
        target = POS_W'(a_begin_reg) + ((a_finish_reg - POS_W'(a_begin_reg)) >> 1);
        below  = a_total_reg < detect_prod_reg;
        obstacle_latch_next = obstacle_latch_reg || (a_move && below);

        heading_sum = SUM_W'(angle_min_reg) + signed'(SUM_W'(c_prod_reg));
        if (heading_sum > SUM_W'(PI_URAD))
            heading_sat = ANGLE_W'(PI_URAD);
        else if (heading_sum < -SUM_W'(PI_URAD))
            heading_sat = -ANGLE_W'(PI_URAD);
        else
            heading_sat = heading_sum[ANGLE_W-1:0];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            a_valid_reg        <= 1'b0;
            b_valid_reg        <= 1'b0;
            c_valid_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
            beam_counter_reg   <= '0;
            run_open_reg       <= 1'b0;
            run_begin_reg      <= '0;
            best_begin_reg     <= '0;
            best_finish_reg    <= '0;
            best_length_reg    <= '0;
            window_total_reg   <= '0;
            obstacle_latch_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (a_ready)
                a_valid_reg <= proc && last_beam;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
            if (out_ready)
                out_valid_reg <= c_valid_reg;

            beam_counter_reg   <= beam_counter_next;
            run_open_reg       <= run_open_next;
            run_begin_reg      <= run_begin_next;
            best_begin_reg     <= best_begin_next;
            best_finish_reg    <= best_finish_next;
            best_length_reg    <= best_length_next;
            window_total_reg   <= window_total_next;
            obstacle_latch_reg <= obstacle_latch_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_range_reg <= beam_range_mm;

        if (proc && last_beam)
        begin
            a_begin_reg  <= cand_begin;
            a_finish_reg <= cand_finish;
            a_total_reg  <= total_new;
        end

        if (a_move)
        begin
            b_begin_reg    <= a_begin_reg;
            b_finish_reg   <= a_finish_reg;
            b_target_reg   <= target;
            b_obstacle_reg <= obstacle_latch_next;
        end

        if (b_move)
        begin
            c_begin_reg    <= b_begin_reg;
            c_finish_reg   <= b_finish_reg;
            c_target_reg   <= b_target_reg;
            c_obstacle_reg <= b_obstacle_reg;
            c_prod_reg     <= PROD_W'(b_target_reg * angle_step_reg);
        end

        if (c_move)
        begin
            out_heading_reg  <= heading_sat;
            out_target_reg   <= c_target_reg;
            out_begin_reg    <= c_begin_reg;
            out_finish_reg   <= c_finish_reg;
            out_obstacle_reg <= c_obstacle_reg;
        end
    end

    // Drive the result ports
    assign out_valid         = out_valid_reg;
    assign heading_urad      = out_heading_reg;
    assign target_index      = out_target_reg;
    assign largest_gap_start = out_begin_reg;
    assign largest_gap_end   = out_finish_reg;
    assign obstacle_seen     = out_obstacle_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LFGH_ASSERT_NOW(a_best_length_consistent, 1'b1, best_length_reg == best_finish_reg - POS_W'(best_begin_reg))
    `LFGH_ASSERT_NOW(a_run_begin_not_ahead, run_open_reg, run_begin_reg <= beam_counter_reg)
    `LFGH_ASSERT_NOW(a_gap_ordered, a_valid_reg, a_finish_reg >= POS_W'(a_begin_reg))
    `LFGH_ASSERT_NEXT(a_obstacle_sticky, obstacle_latch_reg, obstacle_latch_reg)

endmodule
